@@ sv/mep_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mep_pkg: shared types, constants and functions of the escape-time pixel block
// Fixed-point formats, coordinate saturation and the sine colour table.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Fixed-point format: sign, 3 integer bits, FRAC_BITS fraction bits
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = FRAC_BITS + 4;
  localparam int MAG_W     = COORD_W - 1;
  localparam int MUL_W     = 2 * MAG_W;
  localparam int PROD_W    = MUL_W - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;

  localparam logic [MAG_W-1:0] COORD_LIM = '1;
  // 4.0 at the width of the sum of squares
  localparam logic [PROD_W:0] FOUR_Q =
    {{(PROD_W - FRAC_BITS - 2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  // Pixel indices and image dimensions
  localparam int IDX_W     = 12;
  localparam int DIM_W     = 13;
  localparam int DIM_LIMIT = 4096;
  localparam int NUM_W     = IDX_W + 3;
  localparam int DIVD_W    = NUM_W;
  localparam int QUO_W     = FRAC_BITS + 3;
  localparam int DIV_STEPS = DIVD_W + FRAC_BITS;

  // Result field widths
  localparam int COLOUR_W = 8;
  localparam int COUNT_W  = 9;

  // Configuration register indices
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd64;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t re;
    coord_t im;
  } coord_pair_t;

  // Saturate a wide signed sum to the symmetric coordinate range
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] lim;
    lim = $signed({{(SUM_W - MAG_W){1'b0}}, COORD_LIM});
    if (v > lim) begin
      return $signed({1'b0, COORD_LIM});
    end
    if (v < -lim) begin
      return -$signed({1'b0, COORD_LIM});
    end
    return $signed(v[COORD_W-1:0]);
  endfunction

  // --------------------------------------------------------------------------
  // Colour table, built at elaboration with Q6.58 integer arithmetic
  // --------------------------------------------------------------------------
  localparam logic [63:0] Q58_ONE       = 64'h0400_0000_0000_0000;
  localparam logic [63:0] Q58_PI        = 64'h0C90_FDAA_2216_8C23;
  localparam logic [63:0] Q58_TWO_PI    = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] Q58_INV_SQRT2 = 64'h02D4_13CC_CFE7_7992;

  typedef logic [255:0][3*COLOUR_W-1:0] colour_rom_t;

  // Signed product, magnitude truncated to 58 fraction bits
  function automatic logic signed [63:0] rom_smul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    logic [63:0]  m;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p  = {64'd0, ma} * {64'd0, mb};
    m  = p[121:58];
    return (a[63] ^ b[63]) ? -$signed(m) : $signed(m);
  endfunction

  // Signed quotient by a small positive count, truncated toward zero
  function automatic logic signed [63:0] rom_sdiv(input logic signed [63:0] a,
                                                  input int n);
    logic [63:0] ma;
    logic [63:0] d;
    logic [63:0] rem;
    logic [63:0] q;
    ma  = a[63] ? 64'(-a) : 64'(a);
    d   = 64'(n);
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], ma[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return a[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [COLOUR_W-1:0] rom_to_byte(input logic signed [63:0] v);
    logic [63:0] t;
    if (v <= 64'sd0) begin
      return '0;
    end
    if (v >= $signed(Q58_ONE)) begin
      return '1;
    end
    t = (64'(v) >> 10) * 64'd255;
    return t[55:48];
  endfunction

  // Each entry is {red, green, blue} for count k
  function automatic colour_rom_t build_colour_rom();
    colour_rom_t             t;
    logic [63:0]             x;
    logic signed [63:0]      r;
    logic signed [63:0]      term;
    logic signed [63:0]      s;
    logic signed [63:0]      c;
    for (int k = 0; k < 256; k++) begin
      x = (64'(k) << 55) % Q58_TWO_PI;
      r = $signed(x);
      if (x > Q58_PI) begin
        r = $signed(x - Q58_TWO_PI);
      end
      term = $signed(Q58_ONE);
      s    = '0;
      c    = $signed(Q58_ONE);
      // Taylor series of sine and cosine together
      for (int n = 1; n < 40; n++) begin
        term = rom_sdiv(rom_smul(term, r), n);
        case (2'(n))
          2'd0:    c = c + term;
          2'd1:    s = s + term;
          2'd2:    c = c - term;
          default: s = s - term;
        endcase
      end
      t[k] = {rom_to_byte(s),
              rom_to_byte(rom_smul(s + c, $signed(Q58_INV_SQRT2))),
              rom_to_byte(c)};
    end
    return t;
  endfunction

  localparam colour_rom_t COLOUR_ROM = build_colour_rom();

endpackage
`default_nettype wire

@@ sv/mep_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mep_fifo: small register queue
// Decouples the coordinate mapper from the iteration engine.
// ----------------------------------------------------------------------------
module mep_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("mep_fifo: pointers apart in an empty queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("mep_fifo: word popped from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("mep_fifo: fill count beyond depth");
`endif

endmodule
`default_nettype wire

@@ sv/mep_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mep_map: pixel to complex point mapper
// Accepts a pixel word and turns row and column into the point c with two
// restoring dividers running side by side, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mep_map (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [mep_pkg::IDX_W-1:0]    in_pixel_row,
  input  wire logic [mep_pkg::IDX_W-1:0]    in_pixel_col,
  input  wire logic [mep_pkg::DIM_W-1:0]    image_width,
  input  wire logic [mep_pkg::DIM_W-1:0]    image_height,
  output logic                              q_push,
  input  wire logic                         q_full,
  output mep_pkg::coord_pair_t              q_wdata
);

  localparam int NL     = 2;      // lane 0: real / column, lane 1: imaginary / row
  localparam int STEP_W = $clog2(mep_pkg::DIV_STEPS);

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_SETUP = 4'b0010,
    M_DIV   = 4'b0100,
    M_PUSH  = 4'b1000
  } map_state_t;

  map_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [mep_pkg::IDX_W-1:0]     idx_r   [NL];
  logic [mep_pkg::DIM_W-1:0]     dim_r   [NL];
  logic [mep_pkg::DIV_STEPS-1:0] divd_r  [NL];
  logic [mep_pkg::DIM_W-1:0]     rem_r   [NL];
  logic [mep_pkg::QUO_W-1:0]     quo_r   [NL];
  logic                          neg_r   [NL];
  logic                          sat_r   [NL];

  logic [mep_pkg::DIV_STEPS-1:0] divd_nxt [NL];
  logic [mep_pkg::DIM_W-1:0]     rem_nxt  [NL];
  logic [mep_pkg::QUO_W-1:0]     quo_nxt  [NL];
  logic                          neg_nxt  [NL];
  logic                          sat_nxt  [NL];

  logic signed [mep_pkg::NUM_W-1:0] num     [NL];
  logic [mep_pkg::NUM_W-2:0]        num_mag [NL];
  logic [mep_pkg::DIVD_W-1:0]       dvd     [NL];
  logic [mep_pkg::DIM_W:0]          rem_sh  [NL];
  logic                             ge      [NL];
  logic [mep_pkg::COORD_W-1:0]      c_mag   [NL];
  mep_pkg::coord_t                  coord   [NL];

  logic accept;

  // Zero reads as one, anything above the limit as the limit
  function automatic logic [mep_pkg::DIM_W-1:0] clamp_dim(
    input logic [mep_pkg::DIM_W-1:0] d);
    if (d == '0) begin
      return mep_pkg::DIM_W'(1);
    end
    if (d > mep_pkg::DIM_W'(mep_pkg::DIM_LIMIT)) begin
      return mep_pkg::DIM_W'(mep_pkg::DIM_LIMIT);
    end
    return d;
  endfunction

  assign in_full = (state_r != M_IDLE);
  assign accept  = in_push && !in_full;
  assign q_push  = (state_r == M_PUSH);

  // Per-lane arithmetic: numerator, divider step, signed result
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      num[l]     = $signed({2'b00, idx_r[l], 1'b1}) - $signed({2'b00, dim_r[l]});
      num_mag[l] = num[l][mep_pkg::NUM_W-1] ? (mep_pkg::NUM_W-1)'(-num[l])
                                            : (mep_pkg::NUM_W-1)'(num[l]);
      dvd[l]     = {num_mag[l], 1'b0};
      rem_sh[l]  = {rem_r[l], divd_r[l][mep_pkg::DIV_STEPS-1]};
      ge[l]      = (rem_sh[l] >= {1'b0, dim_r[l]});
      c_mag[l]   = sat_r[l] ? {1'b0, mep_pkg::COORD_LIM} : {1'b0, quo_r[l]};
      coord[l]   = neg_r[l] ? -$signed(c_mag[l]) : $signed(c_mag[l]);
    end
  end

  assign q_wdata.re = coord[0];
  assign q_wdata.im = coord[1];

  // Sequencer and divider datapath
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    for (int l = 0; l < NL; l++) begin
      divd_nxt[l] = divd_r[l];
      rem_nxt[l]  = rem_r[l];
      quo_nxt[l]  = quo_r[l];
      neg_nxt[l]  = neg_r[l];
      sat_nxt[l]  = sat_r[l];
    end
    case (state_r)
      M_IDLE: begin
        if (accept) begin
          state_nxt = M_SETUP;
        end
      end
      M_SETUP: begin
        for (int l = 0; l < NL; l++) begin
          neg_nxt[l]  = num[l][mep_pkg::NUM_W-1];
          sat_nxt[l]  = ({1'b0, dvd[l]} >= {dim_r[l], 3'b000});
          divd_nxt[l] = {dvd[l], {mep_pkg::FRAC_BITS{1'b0}}};
          rem_nxt[l]  = '0;
          quo_nxt[l]  = '0;
        end
        step_nxt  = '0;
        state_nxt = M_DIV;
      end
      M_DIV: begin
        for (int l = 0; l < NL; l++) begin
          rem_nxt[l]  = ge[l] ? mep_pkg::DIM_W'(rem_sh[l] - {1'b0, dim_r[l]})
                              : rem_sh[l][mep_pkg::DIM_W-1:0];
          quo_nxt[l]  = {quo_r[l][mep_pkg::QUO_W-2:0], ge[l]};
          divd_nxt[l] = divd_r[l] << 1;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(mep_pkg::DIV_STEPS - 1)) begin
          state_nxt = M_PUSH;
        end
      end
      M_PUSH: begin
        if (!q_full) begin
          state_nxt = M_IDLE;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Lane payload
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r[0] <= in_pixel_col;
      idx_r[1] <= in_pixel_row;
      dim_r[0] <= clamp_dim(image_width);
      dim_r[1] <= clamp_dim(image_height);
    end
    for (int l = 0; l < NL; l++) begin
      divd_r[l] <= divd_nxt[l];
      rem_r[l]  <= rem_nxt[l];
      quo_r[l]  <= quo_nxt[l];
      neg_r[l]  <= neg_nxt[l];
      sat_r[l]  <= sat_nxt[l];
    end
  end

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_DIV) |-> (rem_r[0] < dim_r[0]) && (rem_r[1] < dim_r[1]))
    else $error("mep_map: partial remainder not below divisor");
`endif

endmodule
`default_nettype wire

@@ sv/mep_iter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mep_iter: escape-time iteration engine
// Runs z = z*z + c on three shared multipliers, one multiply state and one add state per iteration,
// looks up the colour and holds the result word in the output register.
// ----------------------------------------------------------------------------
module mep_iter #(
  parameter int MAX_ITERATIONS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  output logic                                 q_pop,
  input  wire mep_pkg::coord_pair_t            q_rdata,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [mep_pkg::COLOUR_W-1:0]         out_red,
  output logic [mep_pkg::COLOUR_W-1:0]         out_green,
  output logic [mep_pkg::COLOUR_W-1:0]         out_blue,
  output logic [mep_pkg::COUNT_W-1:0]          out_iteration_count,
  output logic                                 out_escaped
);

  localparam int ITW = $clog2(MAX_ITERATIONS + 1);
  localparam int CW  = mep_pkg::COLOUR_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ADD  = 4'b0100,
    S_OUT  = 4'b1000
  } iter_state_t;

  iter_state_t state_r, state_nxt;
  logic [ITW-1:0] it_r, it_nxt;
  logic           esc_r, esc_nxt;
  logic           ov_r, ov_nxt;

  mep_pkg::coord_t cr_r, ci_r, zr_r, zi_r;
  mep_pkg::coord_t zr_nxt, zi_nxt;
  logic [mep_pkg::PROD_W-1:0] rr_r, ii_r, pr_r;
  logic                       psgn_r;

  logic [mep_pkg::MAG_W-1:0]  mzr, mzi;
  logic [mep_pkg::MUL_W-1:0]  sq_re, sq_im, prod_ri;
  logic [mep_pkg::PROD_W:0]   sumsq;
  logic                       escape_now;
  logic [mep_pkg::MAG_W-1:0]  p_mag;
  mep_pkg::coord_t            p_val;
  logic signed [mep_pkg::SUM_W-1:0] re_sum, im_sum;
  logic [3*CW-1:0]            colour;
  logic                       load_out;
  logic                       pop_word;

  assign pop_word  = (state_r == S_IDLE) && !q_empty;
  assign q_pop     = pop_word;
  assign load_out  = (state_r == S_OUT) && (!ov_r || out_pop);
  assign out_empty = !ov_r;

  // Multiply stage: magnitudes and three products
  assign mzr     = zr_r[mep_pkg::COORD_W-1] ? mep_pkg::MAG_W'(-zr_r) : mep_pkg::MAG_W'(zr_r);
  assign mzi     = zi_r[mep_pkg::COORD_W-1] ? mep_pkg::MAG_W'(-zi_r) : mep_pkg::MAG_W'(zi_r);
  assign sq_re   = mep_pkg::MUL_W'(mzr) * mep_pkg::MUL_W'(mzr);
  assign sq_im   = mep_pkg::MUL_W'(mzi) * mep_pkg::MUL_W'(mzi);
  assign prod_ri = mep_pkg::MUL_W'(mzr) * mep_pkg::MUL_W'(mzi);

  // Add stage: escape test and next z
  assign sumsq      = {1'b0, rr_r} + {1'b0, ii_r};
  assign escape_now = (sumsq > mep_pkg::FOUR_Q);
  assign p_mag      = (pr_r > mep_pkg::PROD_W'(mep_pkg::COORD_LIM))
                      ? mep_pkg::COORD_LIM : pr_r[mep_pkg::MAG_W-1:0];
  assign p_val      = psgn_r ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
  assign re_sum     = $signed({2'b00, rr_r}) - $signed({2'b00, ii_r})
                      + mep_pkg::SUM_W'(cr_r);
  assign im_sum     = (mep_pkg::SUM_W'(p_val) <<< 1) + mep_pkg::SUM_W'(ci_r);
  assign zr_nxt     = mep_pkg::sat_coord(re_sum);
  assign zi_nxt     = mep_pkg::sat_coord(im_sum);

  // Colour table, indexed by the count modulo 256
  assign colour = mep_pkg::COLOUR_ROM[8'(it_r)];

  // Control sequence
  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    esc_nxt   = esc_r;
    ov_nxt    = ov_r;
    if (out_pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (pop_word) begin
          it_nxt    = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (escape_now) begin
          esc_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          it_nxt = it_r + 1'b1;
          if (it_r + 1'b1 == ITW'(MAX_ITERATIONS)) begin
            esc_nxt   = 1'b0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (load_out) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      it_r    <= '0;
      esc_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
      esc_r   <= esc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop_word) begin
      cr_r <= q_rdata.re;
      ci_r <= q_rdata.im;
      zr_r <= q_rdata.re;
      zi_r <= q_rdata.im;
    end else if (state_r == S_ADD) begin
      zr_r <= zr_nxt;
      zi_r <= zi_nxt;
    end
    if (state_r == S_MUL) begin
      rr_r   <= sq_re[mep_pkg::MUL_W-1:mep_pkg::FRAC_BITS];
      ii_r   <= sq_im[mep_pkg::MUL_W-1:mep_pkg::FRAC_BITS];
      pr_r   <= prod_ri[mep_pkg::MUL_W-1:mep_pkg::FRAC_BITS];
      psgn_r <= zr_r[mep_pkg::COORD_W-1] ^ zi_r[mep_pkg::COORD_W-1];
    end
  end

  // Output word register; black when the point stays bounded
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red             <= esc_r ? colour[3*CW-1:2*CW] : '0;
      out_green           <= esc_r ? colour[2*CW-1:CW]   : '0;
      out_blue            <= esc_r ? colour[CW-1:0]      : '0;
      out_iteration_count <= mep_pkg::COUNT_W'(it_r);
      out_escaped         <= esc_r;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    it_r <= ITW'(MAX_ITERATIONS))
    else $error("mep_iter: iteration count beyond limit");
`endif

endmodule
`default_nettype wire

@@ sv/mandelbrot_escape_pixel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel: escape-time colouring of one Mandelbrot pixel
// Maps (row, col) to a point c in Q4.28, iterates z = z*z + c and returns
// the escape count, an escaped flag and a sine-table colour.
// ----------------------------------------------------------------------------
// Usage: push one pixel word (row, col); one result word per pixel comes out
// in order. The front end maps a pixel with its two 43-step restoring
// dividers running in parallel; it then takes the next pixel while the back
// end is still iterating. The back end runs one multiply state and one add
// state per iteration on the single set of three multipliers, until the
// point escapes or MAX_ITERATIONS is reached. Sustained throughput is set by
// the slower of the two ends. A two-word queue sits between front and back,
// and the output register lets the engine finish the next pixel while a
// result waits. Write image_width and image_height only while the block is
// idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel #(
  parameter int MAX_ITERATIONS = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // pixel words in
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire logic [mep_pkg::IDX_W-1:0]          in_pixel_row,
  input  wire logic [mep_pkg::IDX_W-1:0]          in_pixel_col,
  // result words out
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output logic [mep_pkg::COLOUR_W-1:0]            out_red,
  output logic [mep_pkg::COLOUR_W-1:0]            out_green,
  output logic [mep_pkg::COLOUR_W-1:0]            out_blue,
  output logic [mep_pkg::COUNT_W-1:0]             out_iteration_count,
  output logic                                    out_escaped,
  // configuration writes
  input  wire logic                               cfg_we,
  input  wire logic [mep_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [mep_pkg::DIM_W-1:0]          cfg_wdata
);

  localparam int QW = $bits(mep_pkg::coord_pair_t);

  logic [mep_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [mep_pkg::DIM_W-1:0] height_r, height_nxt;

  logic                 q_push, q_full, q_pop, q_empty;
  mep_pkg::coord_pair_t q_wdata, q_rdata;
  logic [QW-1:0]        q_rdata_bits;

  // Configuration registers
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_addr)
        mep_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        mep_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mep_pkg::IMAGE_WIDTH_RST;
      height_r <= mep_pkg::IMAGE_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Front end: pixel to point
  mep_map u_map (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_pixel_row (in_pixel_row),
    .in_pixel_col (in_pixel_col),
    .image_width  (width_r),
    .image_height (height_r),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_wdata      (q_wdata)
  );

  // Point queue
  mep_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata_bits)
  );

  assign q_rdata = q_rdata_bits;

  // Back end: iteration and colour
  mep_iter #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_iter (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_rdata             (q_rdata),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped)
  );

endmodule
`default_nettype wire
